### rtl/rbs_pkg.sv
// Shared constants, codes and helper functions for the random backend selector.
`timescale 1ns / 1ps

package rbs_pkg;

    localparam int MAX_SERVERS_DEF = 16;
    localparam int LFSR_W          = 16;
    localparam int ID_W            = 6;
    localparam int MASK_W          = 64;
    localparam int MODE_W          = 2;
    localparam int STATUS_W        = 3;
    localparam int COUNT_OUT_W     = 5;

    localparam logic [LFSR_W-1:0] SEED_DEFAULT = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS    = 16'hB400;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEL    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEL    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE_READY = 3'd4;

    // One Galois step: shift right, fold taps in when a one drops out.
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

    // A zero seed would lock the generator.
    function automatic logic [LFSR_W-1:0] seed_value(input logic [LFSR_W-1:0] v);
        return (v == '0) ? SEED_DEFAULT : v;
    endfunction

endpackage

### rtl/random_backend_selector.sv
// Top level: server table sequencer for add, delete and random select.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// in        request    i_in_valid / o_in_ready      i_mode, i_server_id, i_ready_mask
// out       result     o_out_valid / i_out_ready    o_status, o_chosen_server, o_server_count
// cfg       write      i_lfsr_seed_we               i_lfsr_seed
//
// Add, unused mode and the empty or full cases go straight to the done state and the output register.
// Delete reads and compares each entry in turn, then moves the last entry into the matching slot.
// Select makes up to count tries, each waiting on the bit-serial remainder unit and then
// checking the picked entry. One request at a time; the next is taken while a result waits.
// Synchronous active-low reset clears the count and loads the default seed.
// A stalled result holds the sequencer in its final state until taken.

module random_backend_selector #(
    parameter int MAX_SERVERS = rbs_pkg::MAX_SERVERS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_lfsr_seed_we,
    input  logic [rbs_pkg::LFSR_W-1:0]      i_lfsr_seed,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [rbs_pkg::MODE_W-1:0]      i_mode,
    input  logic [rbs_pkg::ID_W-1:0]        i_server_id,
    input  logic [rbs_pkg::MASK_W-1:0]      i_ready_mask,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rbs_pkg::STATUS_W-1:0]    o_status,
    output logic [rbs_pkg::ID_W-1:0]        o_chosen_server,
    output logic [rbs_pkg::COUNT_OUT_W-1:0] o_server_count
);

    localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CW = $clog2(MAX_SERVERS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_MOVE  = 7'b0001000,
        S_MOD   = 7'b0010000,
        S_CHECK = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                            r_state, n_state;
    logic [CW-1:0]                     r_count, n_count;
    logic [AW-1:0]                     r_idx, n_idx;
    logic [rbs_pkg::LFSR_W-1:0]        r_lfsr, n_lfsr;
    logic [rbs_pkg::ID_W-1:0]          r_id;
    logic [rbs_pkg::MASK_W-1:0]        r_mask;
    logic [rbs_pkg::STATUS_W-1:0]      r_res_status, n_res_status;
    logic [rbs_pkg::ID_W-1:0]          r_res_chosen, n_res_chosen;
    logic                              r_out_valid;
    logic [rbs_pkg::STATUS_W-1:0]      r_out_status;
    logic [rbs_pkg::ID_W-1:0]          r_out_chosen;
    logic [rbs_pkg::COUNT_OUT_W-1:0]   r_out_count;

    logic                              w_accept;
    logic                              w_load_out;
    logic                              w_last;
    logic [rbs_pkg::LFSR_W-1:0]        w_lfsr_next;
    logic                              w_tbl_we;
    logic [AW-1:0]                     w_tbl_waddr;
    logic [rbs_pkg::ID_W-1:0]          w_tbl_wdata;
    logic [AW-1:0]                     w_tbl_raddr;
    logic [rbs_pkg::ID_W-1:0]          w_tbl_rdata;
    logic                              w_div_start;
    logic                              w_div_done;
    logic [CW-1:0]                     w_div_rem;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign w_lfsr_next = rbs_pkg::lfsr_step(r_lfsr);
    assign w_last      = ((CW'(r_idx) + CW'(1)) == r_count);

    rbs_table #(
        .DEPTH (MAX_SERVERS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tbl_we),
        .i_waddr (w_tbl_waddr),
        .i_wdata (w_tbl_wdata),
        .i_raddr (w_tbl_raddr),
        .o_rdata (w_tbl_rdata)
    );

    rbs_mod #(
        .CW (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_lfsr_next),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_lfsr       = r_lfsr;
        n_res_status = r_res_status;
        n_res_chosen = r_res_chosen;
        w_tbl_we     = 1'b0;
        w_tbl_waddr  = r_idx;
        w_tbl_wdata  = w_tbl_rdata;
        w_tbl_raddr  = r_idx;
        w_div_start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_chosen = '0;
                    n_res_status = rbs_pkg::ST_OK;
                    n_idx        = '0;
                    n_state      = S_DONE;
                    case (i_mode)
                        rbs_pkg::MODE_ADD: begin
                            if (r_count >= CW'(MAX_SERVERS)) begin
                                n_res_status = rbs_pkg::ST_FULL;
                            end else begin
                                w_tbl_we    = 1'b1;
                                w_tbl_waddr = AW'(r_count);
                                w_tbl_wdata = i_server_id;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        rbs_pkg::MODE_DEL: begin
                            if (r_count == '0) begin
                                n_res_status = rbs_pkg::ST_NOT_FOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        rbs_pkg::MODE_SEL: begin
                            if (r_count == '0) begin
                                n_res_status = rbs_pkg::ST_EMPTY;
                            end else begin
                                n_lfsr      = w_lfsr_next;
                                w_div_start = 1'b1;
                                n_state     = S_MOD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                w_tbl_raddr = r_idx;
                n_state     = S_CMP;
            end
            S_CMP: begin
                // fetch the last entry now in case this one matches
                w_tbl_raddr = AW'(r_count - CW'(1));
                if (w_tbl_rdata == r_id) begin
                    n_state = S_MOVE;
                end else if (w_last) begin
                    n_res_status = rbs_pkg::ST_NOT_FOUND;
                    n_state      = S_DONE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_SCAN;
                end
            end
            S_MOVE: begin
                w_tbl_we     = 1'b1;
                w_tbl_waddr  = r_idx;
                w_tbl_wdata  = w_tbl_rdata;
                n_count      = r_count - CW'(1);
                n_res_status = rbs_pkg::ST_OK;
                n_state      = S_DONE;
            end
            S_MOD: begin
                w_tbl_raddr = AW'(w_div_rem);
                if (w_div_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_mask[w_tbl_rdata]) begin
                    n_res_status = rbs_pkg::ST_OK;
                    n_res_chosen = w_tbl_rdata;
                    n_state      = S_DONE;
                end else if (w_last) begin
                    n_res_status = rbs_pkg::ST_NONE_READY;
                    n_state      = S_DONE;
                end else begin
                    n_idx       = r_idx + AW'(1);
                    n_lfsr      = w_lfsr_next;
                    w_div_start = 1'b1;
                    n_state     = S_MOD;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_lfsr      <= rbs_pkg::SEED_DEFAULT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (i_lfsr_seed_we) begin
                r_lfsr <= rbs_pkg::seed_value(i_lfsr_seed);
            end else begin
                r_lfsr <= n_lfsr;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id   <= i_server_id;
            r_mask <= i_ready_mask;
        end
        r_res_status <= n_res_status;
        r_res_chosen <= n_res_chosen;
        if (w_load_out) begin
            r_out_status <= r_res_status;
            r_out_chosen <= r_res_chosen;
            r_out_count  <= rbs_pkg::COUNT_OUT_W'(r_count);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_chosen_server = r_out_chosen;
    assign o_server_count  = r_out_count;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("request accepted while previous one still in progress");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SERVERS))
        else $error("entry count beyond table depth");

    a_mod_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_MOD))
        else $error("remainder finished outside select sequence");

    a_try_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK || r_state == S_CMP) |-> (CW'(r_idx) < r_count))
        else $error("walk index past entry count");
`endif

endmodule

### rtl/rbs_table.sv
// Server id table: one write port, one registered read port.
`timescale 1ns / 1ps

module rbs_table #(
    parameter int DEPTH = rbs_pkg::MAX_SERVERS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [rbs_pkg::ID_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic [rbs_pkg::ID_W-1:0] o_rdata
);

    logic [rbs_pkg::ID_W-1:0] r_mem [DEPTH];
    logic [rbs_pkg::ID_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rbs_mod.sv
// Iterative remainder unit: 16-bit value modulo a small count, one bit per cycle.
`timescale 1ns / 1ps

module rbs_mod #(
    parameter int CW = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rbs_pkg::LFSR_W-1:0] i_dividend,
    input  logic [CW-1:0]              i_divisor,
    output logic                       o_done,
    output logic [CW-1:0]              o_rem
);

    localparam int NW = $clog2(rbs_pkg::LFSR_W);

    logic                       r_busy;
    logic                       r_done;
    logic [NW-1:0]              r_cnt;
    logic [rbs_pkg::LFSR_W-1:0] r_quo;
    logic [CW-1:0]              r_rem;
    logic [CW-1:0]              r_div;
    logic [CW:0]                w_trial;
    logic [CW:0]                w_next;

    // restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_quo[rbs_pkg::LFSR_W-1]};
        if (w_trial >= {1'b0, r_div}) begin
            w_next = w_trial - {1'b0, r_div};
        end else begin
            w_next = w_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + NW'(1);
                if (r_cnt == NW'(rbs_pkg::LFSR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= r_quo << 1;
            r_rem <= w_next[CW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### sim/tb_random_backend_selector.sv
// Self-checking testbench for the random backend selector: scoreboard class and stimulus top.
`timescale 1ns / 1ps

typedef struct packed {
    logic [rbs_pkg::STATUS_W-1:0]    status;
    logic [rbs_pkg::ID_W-1:0]        chosen;
    logic [rbs_pkg::COUNT_OUT_W-1:0] count;
} selector_result_t;

class selector_scoreboard;
    localparam int               MAX_ENTRIES = 16;
    localparam logic [15:0]      RESET_SEED  = 16'hACE1;
    localparam logic [15:0]      GALOIS_TAPS = 16'hB400;

    logic [rbs_pkg::ID_W-1:0] slots [MAX_ENTRIES];
    int                       n_entries;
    logic [15:0]              lfsr;
    selector_result_t         awaited_results [$];
    int                       errors;

    function void reset_state();
        n_entries = 0;
        errors = 0;
        awaited_results.delete();
        load_seed(RESET_SEED);
    endfunction

    function void load_seed(logic [15:0] s);
        lfsr = (s == 16'h0) ? RESET_SEED : s;
    endfunction

    function logic [15:0] galois_next(logic [15:0] v);
        return (v >> 1) ^ (v[0] ? GALOIS_TAPS : 16'h0);
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction

    // Update the table model for an accepted request and queue its result.
    function void log_request(logic [1:0] mode, logic [5:0] id, logic [63:0] mask);
        selector_result_t r;
        int               pick;
        r.status = rbs_pkg::ST_OK;
        r.chosen = '0;
        case (mode)
            rbs_pkg::MODE_ADD: begin
                if (n_entries >= MAX_ENTRIES) begin
                    r.status = rbs_pkg::ST_FULL;
                end else begin
                    slots[n_entries] = id;
                    n_entries++;
                end
            end
            rbs_pkg::MODE_DEL: begin
                r.status = rbs_pkg::ST_NOT_FOUND;
                for (int i = 0; i < n_entries; i++) begin
                    if (slots[i] == id) begin
                        slots[i] = slots[n_entries-1];
                        n_entries--;
                        r.status = rbs_pkg::ST_OK;
                        break;
                    end
                end
            end
            rbs_pkg::MODE_SEL: begin
                if (n_entries == 0) begin
                    r.status = rbs_pkg::ST_EMPTY;
                end else begin
                    r.status = rbs_pkg::ST_NONE_READY;
                    for (int i = 0; i < n_entries; i++) begin
                        lfsr = galois_next(lfsr);
                        pick = int'(lfsr) % n_entries;
                        if (mask[slots[pick]]) begin
                            r.chosen = slots[pick];
                            r.status = rbs_pkg::ST_OK;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.count = n_entries[rbs_pkg::COUNT_OUT_W-1:0];
        awaited_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
        if (errors < 40) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        errors++;
    endtask

    task check_reply(logic [2:0] status, logic [5:0] chosen, logic [4:0] count);
        selector_result_t e;
        if (awaited_results.size() == 0) begin
            report_mismatch("result with no request outstanding");
        end else begin
            e = awaited_results.pop_front();
            if (status !== e.status) begin
                report_mismatch($sformatf("status %0d, want %0d", status, e.status));
            end
            if (chosen !== e.chosen) begin
                report_mismatch($sformatf("chosen_server %0d, want %0d", chosen, e.chosen));
            end
            if (count !== e.count) begin
                report_mismatch($sformatf("server_count %0d, want %0d", count, e.count));
            end
        end
    endtask
endclass

module tb_random_backend_selector;
    import rbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 290;
    localparam int NUM_PHASES     = 5;
    localparam int TAIL_CYCLES    = 60;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_lfsr_seed_we;
    logic [LFSR_W-1:0]      i_lfsr_seed;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [MODE_W-1:0]      i_mode;
    logic [ID_W-1:0]        i_server_id;
    logic [MASK_W-1:0]      i_ready_mask;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [STATUS_W-1:0]    o_status;
    logic [ID_W-1:0]        o_chosen_server;
    logic [COUNT_OUT_W-1:0] o_server_count;

    selector_scoreboard sb;
    bit                 quiet;
    int                 add_weight;
    int                 stall_cycles;

    random_backend_selector dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_lfsr_seed_we  (i_lfsr_seed_we),
        .i_lfsr_seed     (i_lfsr_seed),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_server_id     (i_server_id),
        .i_ready_mask    (i_ready_mask),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_chosen_server (o_chosen_server),
        .o_server_count  (o_server_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (quiet || r < 10) begin
            return 0;
        end
        if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_reply(o_status, o_chosen_server, o_server_count);
        end
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("random_backend_selector test failed");
        $finish;
    end

    // Result side back-pressure.
    initial begin
        int hold;
        int gap;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            i_out_ready = 1'b1;
            hold = $urandom_range(1, 30);
            repeat (hold - 1) @(negedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                @(negedge i_clk);
                i_out_ready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    // Returns at the rising edge where the request was taken; valid stays up.
    task automatic send_request(logic [1:0] mode, logic [5:0] id, logic [63:0] mask);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_mode       = mode;
        i_server_id  = id;
        i_ready_mask = mask;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.log_request(mode, id, mask);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_seed(logic [15:0] s);
        @(negedge i_clk);
        i_lfsr_seed_we = 1'b1;
        i_lfsr_seed    = s;
        sb.load_seed(s);
        @(negedge i_clk);
        i_lfsr_seed_we = 1'b0;
    endtask

    task automatic send_random_request(output bit counted);
        int          n;
        int          r;
        int          add_pct;
        logic [1:0]  mode;
        logic [5:0]  id;
        logic [63:0] mask;
        n = sb.n_entries;
        add_pct = (n >= 16) ? 8 : (n < 3) ? 50 : add_weight;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            mode = MODE_UNUSED;
        end else if (r < 2 + add_pct) begin
            mode = MODE_ADD;
        end else if (r < 27 + add_pct) begin
            mode = MODE_DEL;
        end else begin
            mode = MODE_SEL;
        end
        // small id pool makes duplicates common
        id = ($urandom_range(0, 9) < 3) ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63));
        if (mode == MODE_DEL && n > 0 && $urandom_range(0, 9) < 8) begin
            id = sb.slots[$urandom_range(0, n - 1)];
        end
        case ($urandom_range(0, 7))
            0: mask = '1;
            1: mask = '0;
            2, 3: mask = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            4, 5: begin
                if (n > 0) begin
                    mask = 64'd1 << sb.slots[$urandom_range(0, n - 1)];
                end else begin
                    mask = {$urandom, $urandom};
                end
            end
            default: mask = {$urandom, $urandom};
        endcase
        send_request(mode, id, mask);
        counted = (mode != MODE_UNUSED);
    endtask

    task automatic run_directed();
        send_request(MODE_SEL, 6'd0, '1);             // empty table
        send_request(MODE_DEL, 6'd5, '0);             // delete on empty
        send_request(MODE_UNUSED, 6'd63, '1);
        send_request(MODE_ADD, 6'd0, '0);
        send_request(MODE_ADD, 6'd63, '1);
        send_request(MODE_SEL, 6'd0, '0);             // nothing ready
        send_request(MODE_SEL, 6'd0, 64'h8000_0000_0000_0000);
        send_request(MODE_DEL, 6'd7, '1);             // absent id
        send_request(MODE_DEL, 6'd0, '0);             // last entry moves into slot 0
        for (int i = 0; i < 15; i++) begin
            send_request(MODE_ADD, 6'((i * 21) & 63), {$urandom, $urandom});
        end
        send_request(MODE_ADD, 6'd9, '1);             // table full
        send_request(MODE_SEL, 6'd0, '1);
        send_request(MODE_SEL, 6'd63, '0);            // all tries miss
        send_request(MODE_DEL, 6'((14 * 21) & 63), '0);
    endtask

    initial begin
        logic [15:0] seeds [NUM_PHASES];
        int          issued;
        bit          counted;
        i_rst_n        = 1'b0;
        i_lfsr_seed_we = 1'b0;
        i_lfsr_seed    = '0;
        i_in_valid     = 1'b0;
        i_mode         = MODE_ADD;
        i_server_id    = '0;
        i_ready_mask   = '0;
        quiet          = 1'b0;
        add_weight     = 30;
        sb = new();
        sb.reset_state();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();

        seeds[0] = 16'hFFFF;
        seeds[1] = 16'h0001;
        seeds[2] = 16'h0000;  // zero falls back to the default seed
        seeds[3] = 16'($urandom);
        seeds[4] = 16'($urandom);
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            write_seed(seeds[p]);
            quiet      = (p == 1);
            add_weight = (p % 2 == 0) ? 35 : 15;
            issued     = 0;
            while (issued < PHASE_ITEMS) begin
                send_random_request(counted);
                if (counted) begin
                    issued++;
                end
            end
        end
        quiet = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report_mismatch("results still outstanding at end of run");
        end
        if (sb.errors == 0) begin
            $display("random_backend_selector test passed");
        end else begin
            $display("random_backend_selector test failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/rbs_pkg.sv
rtl/rbs_table.sv
rtl/rbs_mod.sv
rtl/random_backend_selector.sv
sim/tb_random_backend_selector.sv
